>>> rtl/bda_pkg.sv
// Shared types and constants of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package bda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int NUM_PLACES = 10;
  localparam int RADIX      = 10;
  localparam int DIGIT_W    = 4;
  localparam int PLACE_W    = 4;
  localparam int MULT_W     = 34;

  localparam logic [CHAR_W-1:0]  DIGIT_BASE  = 6'd48;
  localparam logic [PLACE_W-1:0] BUSY_CYCLES = PLACE_W'(NUM_PLACES - 1);

  typedef logic [NUM_PLACES-1:0][RADIX-1:0][MULT_W-1:0] mult_tbl_t;

  // What one cell hands to the next one: the part of the value not yet
  // turned into digits, and whether a nonzero digit has been seen.
  typedef struct packed {
    logic               vld;
    logic               started;
    logic [VALUE_W-1:0] rem;
  } bda_link_t;

  // Entry [p][k] is k times ten to the power p.
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t        tbl;
    logic [MULT_W-1:0] pw;
    pw = MULT_W'(1);
    for (int p = 0; p < NUM_PLACES; p++) begin
      for (int k = 0; k < RADIX; k++) begin
        tbl[p][k] = MULT_W'(k) * pw;
      end
      pw = pw * MULT_W'(RADIX);
    end
    return tbl;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

endpackage
`default_nettype wire

>>> rtl/bda_cell.sv
// One decimal place of the converter chain: extracts a digit and passes the rest on.
`timescale 1ns / 1ps
`default_nettype none
module bda_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bda_pkg::PLACE_W-1:0]   place_i,
  input  wire bda_pkg::bda_link_t            link_i,
  output bda_pkg::bda_link_t                 link_o,
  output logic                               emit_o,
  output logic [bda_pkg::DIGIT_W-1:0]        digit_o
);

  logic [bda_pkg::MULT_W:0]    diff [bda_pkg::RADIX];
  logic [bda_pkg::DIGIT_W-1:0] digit;
  logic [bda_pkg::VALUE_W-1:0] rem_sel;

  logic                        vld_r, vld_nxt;
  logic                        started_r, started_nxt;
  logic                        emit_r, emit_nxt;
  logic [bda_pkg::VALUE_W-1:0] rem_r, rem_nxt;
  logic [bda_pkg::DIGIT_W-1:0] digit_r, digit_nxt;

  // All ten trial subtractions run side by side; the largest multiple of
  // the place weight that still fits gives the digit.
  always_comb begin
    digit   = '0;
    rem_sel = link_i.rem;
    for (int k = 0; k < bda_pkg::RADIX; k++) begin
      diff[k] = {(bda_pkg::MULT_W + 1 - bda_pkg::VALUE_W)'(0), link_i.rem}
              - {1'b0, bda_pkg::MULT_TBL[place_i][k]};
    end
    for (int k = 1; k < bda_pkg::RADIX; k++) begin
      if (!diff[k][bda_pkg::MULT_W]) begin
        digit   = bda_pkg::DIGIT_W'(k);
        rem_sel = diff[k][bda_pkg::VALUE_W-1:0];
      end
    end
  end

  always_comb begin
    vld_nxt     = link_i.vld;
    rem_nxt     = rem_sel;
    digit_nxt   = digit;
    started_nxt = link_i.started | (digit != '0);
    // The units place always shows, which also covers a value of zero.
    emit_nxt    = link_i.vld & (started_nxt | (place_i == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      emit_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      emit_r <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    started_r <= started_nxt;
    rem_r     <= rem_nxt;
    digit_r   <= digit_nxt;
  end

  assign link_o.vld     = vld_r;
  assign link_o.started = started_r;
  assign link_o.rem     = rem_r;
  assign emit_o         = emit_r;
  assign digit_o        = digit_r;

endmodule
`default_nettype wire

>>> rtl/binary_to_decimal_ascii_unit.sv
// Top level of the 32-bit binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
// Usage overview.
// A transaction on the input side is taken at a rising edge where start is
// high and busy is low; in_value carries the unsigned 32-bit number.
// The number walks down a chain of ten cells, one per decimal place, from
// the billions place to the units place, moving one cell per clock. Each
// cell peels off its digit with parallel trial subtractions of the place
// weight and hands the remainder on.
// Because each cell registers the number before handing it on, the
// digits leave most significant first, one per cycle, straight from the
// cell that made them. Leading zeros are dropped, so a number gives one to
// ten result transactions; out_strobe marks each, and out_last marks the
// units digit. A value of zero gives a single '0' with out_last set.
// The first digit can come from the billions cell and the units digit
// always comes from the last cell of the chain. busy is raised after an
// acceptance and held until the busy counter has run down, so a new number
// is taken at the earliest in the same cycle as the previous number's last
// digit. The ten-cell chain sets this spacing: a cell is reused by the next
// number only after the current one has left it.
// The receiver has no way to stall: each result is present for one cycle.
// Reset clears the cell valid flags and the busy counter; a number in
// flight at reset is dropped.
module binary_to_decimal_ascii_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bda_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_strobe,
  output logic [bda_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                               out_last
);

  bda_pkg::bda_link_t          link [bda_pkg::NUM_PLACES+1];
  logic                        emit [bda_pkg::NUM_PLACES];
  logic [bda_pkg::DIGIT_W-1:0] digit [bda_pkg::NUM_PLACES];

  logic                        accept;
  logic [bda_pkg::PLACE_W-1:0] busy_cnt_r, busy_cnt_nxt;

  assign accept = start & ~busy;
  assign busy   = (busy_cnt_r != '0);

  // The counter keeps the chain free of a second number until the first
  // one has passed through all the cells.
  always_comb begin
    busy_cnt_nxt = busy_cnt_r;
    if (accept) begin
      busy_cnt_nxt = bda_pkg::BUSY_CYCLES;
    end else if (busy) begin
      busy_cnt_nxt = busy_cnt_r - bda_pkg::PLACE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= '0;
    end else begin
      busy_cnt_r <= busy_cnt_nxt;
    end
  end

  assign link[0].vld     = accept;
  assign link[0].started = 1'b0;
  assign link[0].rem     = in_value;

  for (genvar i = 0; i < bda_pkg::NUM_PLACES; i++) begin : g_cell
    bda_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .place_i (bda_pkg::PLACE_W'(bda_pkg::NUM_PLACES - 1 - i)),
      .link_i  (link[i]),
      .link_o  (link[i+1]),
      .emit_o  (emit[i]),
      .digit_o (digit[i])
    );
  end

  // The busy counter spaces the numbers so that at most one cell emits in a
  // cycle and the outputs can simply be ORed together.
  always_comb begin
    out_strobe     = 1'b0;
    out_digit_char = '0;
    for (int i = 0; i < bda_pkg::NUM_PLACES; i++) begin
      if (emit[i]) begin
        out_strobe     = 1'b1;
        out_digit_char = out_digit_char
                       | bda_pkg::DIGIT_BASE
                       | bda_pkg::CHAR_W'(digit[i]);
      end
    end
  end

  assign out_last = emit[bda_pkg::NUM_PLACES-1];

  // The last cell's forwarded remainder is always zero and goes unused.
  logic unused_tail;
  assign unused_tail = ^link[bda_pkg::NUM_PLACES];

endmodule
`default_nettype wire

>>> rtl/bda_checker.sv
// Port-level checks of the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bda_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [bda_pkg::VALUE_W-1:0]   in_value,
  input wire logic                          out_strobe,
  input wire logic [bda_pkg::CHAR_W-1:0]    out_digit_char,
  input wire logic                          out_last
);

  // Every emitted character is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_digit_char >= 6'd48 && out_digit_char <= 6'd57))
    else $error("character out of digit range");

  // An accepted transaction blocks the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after acceptance");

  // The units digit only appears once the input side is free again.
  a_last_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (out_strobe && !busy))
    else $error("last digit while busy or without strobe");

  // Zero is rendered as a single '0' at the units slot.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_value == '0) |->
      ##10 (out_strobe && out_last && out_digit_char == 6'd48))
    else $error("zero not rendered as a single 0");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_value       (in_value),
  .out_strobe     (out_strobe),
  .out_digit_char (out_digit_char),
  .out_last       (out_last)
);
`default_nettype wire

>>> tb/binary_to_decimal_ascii_unit_tb.sv
// Self-checking testbench for the 32-bit binary to decimal ASCII converter.
`timescale 1ns / 1ps
module binary_to_decimal_ascii_unit_tb;

  // One expected digit transaction on the result side.
  typedef struct {
    logic [bda_pkg::CHAR_W-1:0] digit_char;
    logic                       last;
  } digit_txn_t;

  // Cycles with no transaction on either side before the run is declared hung.
  // A correct run never sees more than a sender gap plus one full conversion,
  // so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;
  // Extra idle cycles waited once every owed digit has come out.
  localparam int DRAIN_CYCLES = 15;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [bda_pkg::VALUE_W-1:0] in_value = '0;
  logic                        busy;
  logic                        out_strobe;
  logic [bda_pkg::CHAR_W-1:0]  out_digit_char;
  logic                        out_last;

  // Digits still owed by the block, oldest first.
  digit_txn_t pending_digits[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  // When cleared, the sender presents a new number at every opportunity.
  bit         sender_may_pause = 1'b1;

  binary_to_decimal_ascii_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  // Predictor: walks the ten decimal places from the billions down, drops
  // leading zeros, and flags the final digit. Zero yields a lone '0'.
  function automatic void queue_decimal_text(input logic [bda_pkg::VALUE_W-1:0] number);
    int unsigned place_weight;
    int unsigned digit;
    bit          seen_nonzero;
    digit_txn_t  txn;
    place_weight = 32'd1000000000;
    seen_nonzero = 1'b0;
    for (int place = bda_pkg::NUM_PLACES - 1; place >= 0; place--) begin
      digit = (number / place_weight) % bda_pkg::RADIX;
      // The units place is always printed, which covers the zero value.
      if (digit != 0 || seen_nonzero || place == 0) begin
        seen_nonzero   = 1'b1;
        txn.digit_char = bda_pkg::DIGIT_BASE + bda_pkg::CHAR_W'(digit);
        txn.last       = (place == 0);
        pending_digits.push_back(txn);
      end
      place_weight = place_weight / bda_pkg::RADIX;
    end
  endfunction

  // Presents one number until the block takes it. In each cycle the sender
  // may idle at random, with start low and junk on the data port.
  task automatic send_number(input logic [bda_pkg::VALUE_W-1:0] number);
    bit offered;
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      offered  = !(sender_may_pause && $urandom_range(0, 99) < 15);
      start    <= offered;
      in_value <= offered ? number : $urandom;
      // Busy is read before the edge updates it, so this is the value the
      // block itself used to decide acceptance.
      @(posedge clk);
      taken = offered && !busy;
    end
    queue_decimal_text(number);
  endtask

  // Lowers start and waits until every owed digit has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // A number with a chosen count of decimal digits, uniform within that count.
  function automatic logic [bda_pkg::VALUE_W-1:0] number_with_digits(input int count);
    longint unsigned low;
    longint unsigned high;
    low = 1;
    for (int i = 1; i < count; i++) low = low * 10;
    high = (count == 10) ? 64'hFFFF_FFFF : low * 10 - 1;
    if (count == 1) low = 0;
    return $urandom_range(32'(high), 32'(low));
  endfunction

  // Ten random digits with zeros favored, folded into 32 bits, so inner and
  // trailing zero digits show up often.
  function automatic logic [bda_pkg::VALUE_W-1:0] zero_rich_number();
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < bda_pkg::NUM_PLACES; i++) begin
      acc = acc * 10 + (($urandom_range(0, 99) < 45) ? 0 : $urandom_range(1, 9));
    end
    return bda_pkg::VALUE_W'(acc);
  endfunction

  // Extremes of the value range, several digit count boundaries, and the zero case.
  task automatic test_directed_values();
    logic [bda_pkg::VALUE_W-1:0] corner_values[$];
    corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                      32'd100000, 32'd999999999, 32'd1000000000,
                      32'd1000000001, 32'd1234567890, 32'd2147483647,
                      32'd2147483648, 32'd4000000000, 32'd4294967294,
                      32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'd1000000009, 32'd909090909, 32'd3000000000};
    foreach (corner_values[i]) send_number(corner_values[i]);
  endtask

  // The bulk of the run: digit counts spread evenly, plain random words and
  // zero-rich numbers, with random sender pauses.
  task automatic test_random_values(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_number(number_with_digits($urandom_range(1, 10)));
      else if (pick < 75) send_number($urandom);
      else send_number(zero_rich_number());
    end
  endtask

  // A long stretch with the sender never pausing, so every new number lands
  // in the same cycle as the previous number's units digit.
  task automatic test_back_to_back(input int count);
    sender_may_pause = 1'b0;
    test_random_values(count);
    sender_may_pause = 1'b1;
  endtask

  // The sender stops until the block has emptied, then resumes from idle.
  task automatic test_pause_until_empty();
    test_random_values(6);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
  endtask

  // Checks each digit transaction against the oldest owed digit.
  always @(posedge clk) begin
    digit_txn_t owed;
    if (rst_n && out_strobe) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit transaction: digit_char %0d last %0b",
               out_digit_char, out_last);
        mismatch_count++;
      end else begin
        owed = pending_digits.pop_front();
        if (out_digit_char !== owed.digit_char) begin
          $error("digit_char: expected %0d, got %0d", owed.digit_char, out_digit_char);
          mismatch_count++;
        end
        if (out_last !== owed.last) begin
          $error("last: expected %0b, got %0b", owed.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Hang detector: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_values();
    test_random_values(120);
    test_pause_until_empty();
    test_back_to_back(60);
    test_random_values(70);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
